// File: src/tdu_pkg.sv
// Shared types, widths and constants for the tick driven 8N1 UART.
`timescale 1ns / 1ps

package tdu_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 32;

   localparam int TICK_WIDTH  = 27;
   localparam int BAUD_WIDTH  = 25;
   localparam int CSR_WIDTH   = 27;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int K_WIDTH     = 5;
   localparam int DSR_WIDTH   = BAUD_WIDTH + 1;
   localparam int QUOT_WIDTH  = 33;
   localparam int STEP_WIDTH  = $clog2(QUOT_WIDTH);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAUD_RATE = 2'd1;

   localparam logic [TICK_WIDTH-1:0] TICK_RATE_RESET = 27'd1000000;
   localparam logic [BAUD_WIDTH-1:0] BAUD_RATE_RESET = 25'd9600;

   // majority of three samples, indexed by the history
   localparam logic [7:0] MAJORITY_TABLE = 8'b1110_1000;

   typedef enum logic [3:0] {
      RX_WAIT_IDLE = 4'd0,
      RX_WAIT_EDGE = 4'd1,
      RX_CONFIRM   = 4'd2,
      RX_BIT0      = 4'd3,
      RX_BIT1      = 4'd4,
      RX_BIT2      = 4'd5,
      RX_BIT3      = 4'd6,
      RX_BIT4      = 4'd7,
      RX_BIT5      = 4'd8,
      RX_BIT6      = 4'd9,
      RX_BIT7      = 4'd10,
      RX_DELIVER   = 4'd11
   } rx_phase_type;

   typedef enum logic [3:0] {
      TX_IDLE  = 4'd0,
      TX_START = 4'd1,
      TX_D0    = 4'd2,
      TX_D1    = 4'd3,
      TX_D2    = 4'd4,
      TX_D3    = 4'd5,
      TX_D4    = 4'd6,
      TX_D5    = 4'd7,
      TX_D6    = 4'd8,
      TX_D7    = 4'd9,
      TX_STOP  = 4'd10
   } tx_phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RX_DIV,
      SEQ_TX_DIV,
      SEQ_APPLY
   } seq_state_type;

   typedef struct packed {
      logic                 start;
      logic [K_WIDTH-1:0]   k;
   } div_ctrl_type;

   typedef struct packed {
      logic                  apply;
      logic [QUOT_WIDTH-1:0] threshold;
   } engine_ctrl_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  data;
      logic [31:0] total;
   } rx_result_type;

   typedef struct packed {
      logic level;
      logic taken;
   } tx_result_type;

endpackage

// File: src/tdu_div.sv
// Shared serial threshold unit: (k*tick_rate + baud) / (2*baud), one bit per cycle.
`timescale 1ns / 1ps

module tdu_div
   import tdu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [TICK_WIDTH-1:0] tick_rate,
   input  logic [BAUD_WIDTH-1:0] baud_rate,
   output logic                  done,
   output logic [QUOT_WIDTH-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [QUOT_WIDTH-1:0] nq_ff, nq_in;
   logic [DSR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DSR_WIDTH-1:0]  dsr_ff, dsr_in;

   logic [BAUD_WIDTH-1:0] baud_eff;
   logic [QUOT_WIDTH-1:0] numerator;
   logic [DSR_WIDTH:0]    trial;
   logic [DSR_WIDTH:0]    diff;
   logic                  fits;

   always_comb begin
      // zero baud acts as one
      baud_eff  = (baud_rate == '0) ? BAUD_WIDTH'(1) : baud_rate;
      numerator = QUOT_WIDTH'(ctrl.k) * QUOT_WIDTH'(tick_rate) + QUOT_WIDTH'(baud_eff);
      trial     = {rem_ff, nq_ff[QUOT_WIDTH-1]};
      fits      = trial >= {1'b0, dsr_ff};
      diff      = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         nq_in   = numerator;
         rem_in  = '0;
         dsr_in  = {baud_eff, 1'b0};
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DSR_WIDTH-1:0] : trial[DSR_WIDTH-1:0];
         nq_in   = {nq_ff[QUOT_WIDTH-2:0], fits};
         step_in = step_ff + STEP_WIDTH'(1);
         if (step_ff == STEP_WIDTH'(QUOT_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = nq_ff;

endmodule

// File: src/tdu_rx.sv
// Receiver: majority filter, start detect and LSB-first sampling.
`timescale 1ns / 1ps

module tdu_rx
   import tdu_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  engine_ctrl_type    ctrl,
   input  logic               rx_level,
   output logic [K_WIDTH-1:0] k,
   output rx_result_type      result
);

   logic [2:0]               hist_ff, hist_in;
   rx_phase_type             phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [7:0]               shift_ff, shift_in;
   logic [31:0]              total_ff, total_in;

   logic [COUNTER_WIDTH-1:0] cnt_bump;
   logic                     reached;
   logic                     bit_val;
   logic [2:0]               n;
   logic                     valid;
   logic [7:0]               data;

   // half-bit point index for the current phase
   always_comb begin
      unique case (phase_ff)
         RX_CONFIRM: k = K_WIDTH'(1);
         RX_BIT0, RX_BIT1, RX_BIT2, RX_BIT3,
         RX_BIT4, RX_BIT5, RX_BIT6, RX_BIT7:
            k = K_WIDTH'({phase_ff, 1'b0}) - K_WIDTH'(3);
         default: k = '0;
      endcase
   end

   always_comb begin
      hist_in  = {hist_ff[1:0], rx_level};
      bit_val  = MAJORITY_TABLE[hist_in];
      cnt_bump = cnt_ff + COUNTER_WIDTH'(1);
      reached  = QUOT_WIDTH'(cnt_bump) >= ctrl.threshold;
      n        = 3'(phase_ff - RX_BIT0);
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      total_in = total_ff;
      valid    = 1'b0;
      data     = 8'd0;
      unique case (phase_ff)
         RX_WAIT_EDGE: begin
            if (!bit_val) begin
               cnt_in   = '0;
               shift_in = 8'd0;
               phase_in = RX_CONFIRM;
            end
         end
         RX_CONFIRM: begin
            cnt_in = cnt_bump;
            if (reached) begin
               phase_in = bit_val ? RX_WAIT_EDGE : RX_BIT0;
            end
         end
         RX_BIT0, RX_BIT1, RX_BIT2, RX_BIT3,
         RX_BIT4, RX_BIT5, RX_BIT6, RX_BIT7: begin
            cnt_in = cnt_bump;
            if (reached) begin
               if (n == 3'd0) begin
                  shift_in = {7'd0, bit_val};
               end else begin
                  shift_in    = shift_ff;
                  shift_in[n] = shift_ff[n] | bit_val;
               end
               phase_in = rx_phase_type'(phase_ff + 4'd1);
            end
         end
         RX_DELIVER: begin
            valid    = 1'b1;
            data     = shift_ff;
            total_in = total_ff + 32'd1;
            phase_in = RX_WAIT_EDGE;
         end
         default: begin
            phase_in = bit_val ? RX_WAIT_EDGE : RX_WAIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= 3'd0;
         phase_ff <= RX_WAIT_IDLE;
         cnt_ff   <= '0;
         shift_ff <= 8'd0;
         total_ff <= 32'd0;
      end else if (ctrl.apply) begin
         hist_ff  <= hist_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         total_ff <= total_in;
      end
   end

   assign result.valid = valid;
   assign result.data  = data;
   assign result.total = total_in;

endmodule

// File: src/tdu_tx.sv
// Transmitter: start, 8 data bits LSB first, stop.
`timescale 1ns / 1ps

module tdu_tx
   import tdu_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  engine_ctrl_type    ctrl,
   input  logic               tx_pending,
   input  logic [7:0]         tx_data,
   output logic [K_WIDTH-1:0] k,
   output tx_result_type      result
);

   tx_phase_type             phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [7:0]               shift_ff, shift_in;
   logic                     line_ff, line_in;

   logic [COUNTER_WIDTH-1:0] cnt_bump;
   logic                     reached;
   logic                     taken;

   // bit boundary k is twice the phase
   always_comb begin
      unique case (phase_ff)
         TX_START, TX_D0, TX_D1, TX_D2, TX_D3, TX_D4,
         TX_D5, TX_D6, TX_D7, TX_STOP: k = K_WIDTH'({phase_ff, 1'b0});
         default: k = '0;
      endcase
   end

   always_comb begin
      cnt_bump = cnt_ff + COUNTER_WIDTH'(1);
      reached  = QUOT_WIDTH'(cnt_bump) >= ctrl.threshold;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      line_in  = line_ff;
      taken    = 1'b0;
      unique case (phase_ff)
         TX_START, TX_D0, TX_D1, TX_D2, TX_D3, TX_D4, TX_D5, TX_D6: begin
            cnt_in = cnt_bump;
            if (reached) begin
               line_in = shift_ff[0];
               if (phase_ff != TX_D6) begin
                  shift_in = {1'b0, shift_ff[7:1]};
               end
               phase_in = tx_phase_type'(phase_ff + 4'd1);
            end
         end
         TX_D7: begin
            cnt_in = cnt_bump;
            if (reached) begin
               line_in  = 1'b1;
               phase_in = TX_STOP;
            end
         end
         TX_STOP: begin
            cnt_in = cnt_bump;
            if (reached) begin
               phase_in = TX_IDLE;
            end
         end
         default: begin
            phase_in = TX_IDLE;
            if (tx_pending) begin
               shift_in = tx_data;
               line_in  = 1'b0;
               cnt_in   = '0;
               phase_in = TX_START;
               taken    = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= TX_IDLE;
         cnt_ff   <= '0;
         shift_ff <= 8'd0;
         line_ff  <= 1'b1;
      end else if (ctrl.apply) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         line_ff  <= line_in;
      end
   end

   assign result.level = line_in;
   assign result.taken = taken;

endmodule

// File: src/tick_driven_uart_8n1_top.sv
// Top level of the tick driven 8N1 UART: sequencer, config registers, response register.
`timescale 1ns / 1ps
//
// Each request word is one timer tick: the raw receive pin sample plus the
// next transmit byte when tx_pending is set. Each tick yields exactly one
// response word: the transmit pin level, whether the pending byte was taken,
// a received byte when one completes, and the running received-byte count.
//
// Timing: one shared serial divider runs twice per tick, for the receive and
// then the transmit threshold, each a 33-bit serial quotient. req_stall
// stays high from acceptance until the response word is in its register;
// the next request can be taken in the cycle the response turns valid.
//
// The response sits in an output register. A stalled response holds the
// finished tick in the apply step until rsp_stall drops; the next request
// is taken once the word has moved into the register.
//
// csr_index 0 writes tick_rate, 1 writes baud_rate; other indexes are
// dropped. csr_ready is always high; write only while the block is idle.
// Reset (synchronous) restores tick_rate 1000000, baud_rate 9600, idle
// receive and transmit state, tx line high and a zero byte count.

module tick_driven_uart_8n1_top
   import tdu_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_rx_level,
   input  logic                       req_tx_pending,
   input  logic [7:0]                 req_tx_data,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_tx_level,
   output logic                       rsp_tx_taken,
   output logic                       rsp_rx_valid,
   output logic [7:0]                 rsp_rx_data,
   output logic [31:0]                rsp_bytes_received,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_data
);

   seq_state_type state_ff, state_in;

   logic [TICK_WIDTH-1:0] tick_rate_ff;
   logic [BAUD_WIDTH-1:0] baud_rate_ff;

   // latched tick word
   logic       rx_level_ff;
   logic       tx_pending_ff;
   logic [7:0] tx_data_ff;

   logic [QUOT_WIDTH-1:0] rx_thr_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_tx_level_ff;
   logic        rsp_tx_taken_ff;
   logic        rsp_rx_valid_ff;
   logic [7:0]  rsp_rx_data_ff;
   logic [31:0] rsp_bytes_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  div_done;
   logic [QUOT_WIDTH-1:0] div_quot;
   logic [K_WIDTH-1:0]    rx_k;
   logic [K_WIDTH-1:0]    tx_k;
   div_ctrl_type          div_ctrl;
   engine_ctrl_type       rx_ctrl;
   engine_ctrl_type       tx_ctrl;
   rx_result_type         rx_res;
   tx_result_type         tx_res;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:   if (req_valid) state_in = SEQ_RX_DIV;
         SEQ_RX_DIV: if (div_done) state_in = SEQ_TX_DIV;
         SEQ_TX_DIV: if (div_done) state_in = SEQ_APPLY;
         SEQ_APPLY:  if (out_free) state_in = SEQ_IDLE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall         = 1'b1;
      div_ctrl.start    = 1'b0;
      div_ctrl.k        = tx_k;
      rx_ctrl.apply     = 1'b0;
      tx_ctrl.apply     = 1'b0;
      rx_ctrl.threshold = rx_thr_ff;
      tx_ctrl.threshold = div_quot;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall      = 1'b0;
            div_ctrl.start = req_valid;
            div_ctrl.k     = rx_k;
         end
         SEQ_RX_DIV: begin
            // receive threshold done, start the transmit one
            div_ctrl.start = div_done;
         end
         SEQ_TX_DIV: begin
         end
         SEQ_APPLY: begin
            rx_ctrl.apply = out_free;
            tx_ctrl.apply = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rx_ctrl.apply || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         tick_rate_ff <= TICK_RATE_RESET;
         baud_rate_ff <= BAUD_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICK_RATE) begin
               tick_rate_ff <= csr_data[TICK_WIDTH-1:0];
            end else if (csr_index == CSR_BAUD_RATE) begin
               baud_rate_ff <= csr_data[BAUD_WIDTH-1:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rx_level_ff   <= req_rx_level;
         tx_pending_ff <= req_tx_pending;
         tx_data_ff    <= req_tx_data;
      end
      if (state_ff == SEQ_RX_DIV && div_done) begin
         rx_thr_ff <= div_quot;
      end
      if (rx_ctrl.apply) begin
         rsp_tx_level_ff <= tx_res.level;
         rsp_tx_taken_ff <= tx_res.taken;
         rsp_rx_valid_ff <= rx_res.valid;
         rsp_rx_data_ff  <= rx_res.data;
         rsp_bytes_ff    <= rx_res.total;
      end
   end

   tdu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .tick_rate (tick_rate_ff),
      .baud_rate (baud_rate_ff),
      .done      (div_done),
      .quotient  (div_quot)
   );

   tdu_rx #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_rx (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rx_ctrl),
      .rx_level (rx_level_ff),
      .k        (rx_k),
      .result   (rx_res)
   );

   tdu_tx #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_tx (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tx_ctrl),
      .tx_pending (tx_pending_ff),
      .tx_data    (tx_data_ff),
      .k          (tx_k),
      .result     (tx_res)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_level       = rsp_tx_level_ff;
   assign rsp_tx_taken       = rsp_tx_taken_ff;
   assign rsp_rx_valid       = rsp_rx_valid_ff;
   assign rsp_rx_data        = rsp_rx_data_ff;
   assign rsp_bytes_received = rsp_bytes_ff;

endmodule

// File: test/tb_tick_driven_uart_8n1_top.sv
// Testbench for the tick driven 8N1 UART top level: stimulus, tick predictor, response checks.
`timescale 1ns / 1ps
//
// Every request word is one timer tick. The bench drives the receive pin
// with serial frames at a few ticks per bit, with glitches and noise runs.
// It offers transmit bytes at random.
//
// An in-bench model of the receiver and transmitter predicts the response
// word for each accepted tick. The checker compares each accepted response
// field by field with the oldest prediction.
//
// Rates are only rewritten once every predicted word has come back.
// Idle bursts appear on both channels, except in the last part of the run.

module tb_tick_driven_uart_8n1_top
   import tdu_pkg::*;
();

   localparam int CNT_W = COUNTER_WIDTH_DEFAULT;
   // index with no register behind it; writes to it are dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CSR_WIDTH-1:0] CSR_ALL_ONES = '1;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

   typedef struct packed {
      logic        tx_level;
      logic        tx_taken;
      logic        rx_valid;
      logic [7:0]  rx_data;
      logic [31:0] bytes_received;
   } uart_tick_word_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_rx_level;
   logic                       req_tx_pending;
   logic [7:0]                 req_tx_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_tx_level;
   logic                       rsp_tx_taken;
   logic                       rsp_rx_valid;
   logic [7:0]                 rsp_rx_data;
   logic [31:0]                rsp_bytes_received;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]       csr_data;

   tick_driven_uart_8n1_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_level       (req_rx_level),
      .req_tx_pending     (req_tx_pending),
      .req_tx_data        (req_tx_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tx_level       (rsp_tx_level),
      .rsp_tx_taken       (rsp_tx_taken),
      .rsp_rx_valid       (rsp_rx_valid),
      .rsp_rx_data        (rsp_rx_data),
      .rsp_bytes_received (rsp_bytes_received),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // ---------------------------------------------------------------
   // Predicted UART state. It mirrors the block after every tick the
   // block has accepted.
   // ---------------------------------------------------------------
   logic [TICK_WIDTH-1:0] cfg_tick;
   logic [BAUD_WIDTH-1:0] cfg_baud;
   logic [2:0]            line_hist;
   rx_phase_type          rx_state;
   logic [CNT_W-1:0]      rx_ticks;
   logic [7:0]            rx_bits;
   tx_phase_type          tx_state;
   logic [CNT_W-1:0]      tx_ticks;
   logic [7:0]            tx_bits;
   logic                  tx_pin;
   logic [31:0]           rx_total;

   uart_tick_word_type expected_words[$];
   uart_tick_word_type head_word;

   int  error_count   = 0;
   int  ticks_sent    = 0;
   int  words_checked = 0;
   int  bytes_seen    = 0;
   int  frames_sent   = 0;
   bit  req_gaps_on   = 1'b1;
   bit  rsp_stall_on  = 1'b1;

   initial begin
      cfg_tick  = TICK_RATE_RESET;
      cfg_baud  = BAUD_RATE_RESET;
      line_hist = '0;
      rx_state  = RX_WAIT_IDLE;
      rx_ticks  = '0;
      rx_bits   = '0;
      tx_state  = TX_IDLE;
      tx_ticks  = '0;
      tx_bits   = '0;
      tx_pin    = 1'b1;
      rx_total  = '0;
   end

   // Tick count at half-bit point k, rounded; a zero baud rate counts as one.
   function automatic longint unsigned half_bit_limit(input int unsigned k);
      longint unsigned b;
      b = (cfg_baud == '0) ? 64'd1 : 64'(cfg_baud);
      return (64'(k) * 64'(cfg_tick) + b) / (2 * b);
   endfunction

   // Advance the predicted UART by one tick and queue the response word it gives.
   task automatic predict_tick(input logic rx, input logic pend, input logic [7:0] data);
      uart_tick_word_type w;
      logic               line;
      int                 n;
      w = '0;

      // receiver: majority of the last three pin samples
      line_hist = {line_hist[1:0], rx};
      line = (line_hist[0] & line_hist[1]) | (line_hist[0] & line_hist[2]) |
             (line_hist[1] & line_hist[2]);
      case (rx_state)
         RX_WAIT_EDGE: begin
            if (!line) begin
               rx_ticks = '0;
               rx_bits  = '0;
               rx_state = RX_CONFIRM;
            end
         end
         RX_CONFIRM: begin
            rx_ticks = rx_ticks + 1'b1;
            // line back high at the confirm point: it was a glitch
            if (64'(rx_ticks) >= half_bit_limit(1))
               rx_state = line ? RX_WAIT_EDGE : RX_BIT0;
         end
         RX_BIT0, RX_BIT1, RX_BIT2, RX_BIT3, RX_BIT4, RX_BIT5, RX_BIT6, RX_BIT7: begin
            n = int'(rx_state) - int'(RX_BIT0);
            rx_ticks = rx_ticks + 1'b1;
            if (64'(rx_ticks) >= half_bit_limit(3 + 2 * n)) begin
               if (n == 0)
                  rx_bits = {7'd0, line};
               else
                  rx_bits[n] = line;
               rx_state = rx_phase_type'(int'(rx_state) + 1);
            end
         end
         RX_DELIVER: begin
            w.rx_valid = 1'b1;
            w.rx_data  = rx_bits;
            rx_total   = rx_total + 1;
            rx_state   = RX_WAIT_EDGE;
         end
         default: begin
            rx_state = line ? RX_WAIT_EDGE : RX_WAIT_IDLE;
         end
      endcase

      // transmitter
      case (tx_state)
         TX_START, TX_D0, TX_D1, TX_D2, TX_D3, TX_D4, TX_D5, TX_D6: begin
            tx_ticks = tx_ticks + 1'b1;
            if (64'(tx_ticks) >= half_bit_limit(2 * int'(tx_state))) begin
               tx_pin = tx_bits[0];
               if (tx_state != TX_D6)
                  tx_bits = tx_bits >> 1;
               tx_state = tx_phase_type'(int'(tx_state) + 1);
            end
         end
         TX_D7: begin
            tx_ticks = tx_ticks + 1'b1;
            if (64'(tx_ticks) >= half_bit_limit(18)) begin
               tx_pin   = 1'b1;
               tx_state = TX_STOP;
            end
         end
         TX_STOP: begin
            // stop bit
            tx_ticks = tx_ticks + 1'b1;
            if (64'(tx_ticks) >= half_bit_limit(20))
               tx_state = TX_IDLE;
         end
         default: begin
            tx_state = TX_IDLE;
            if (pend) begin
               tx_bits    = data;
               tx_pin     = 1'b0;
               tx_ticks   = '0;
               tx_state   = TX_START;
               w.tx_taken = 1'b1;
            end
         end
      endcase

      w.tx_level       = tx_pin;
      w.bytes_received = rx_total;
      expected_words.push_back(w);
   endtask

   // ---------------------------------------------------------------
   // Clock, reset, initial drive values
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_rx_level   <= 1'b1;
      req_tx_pending <= 1'b0;
      req_tx_data    <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
   end

   // Receiver side: random stall bursts while enabled.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_stall_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: word %0d %s: got %0h, expected %0h", $realtime, words_checked,
               what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            report_mismatch("response with no tick outstanding", 32'd0, 32'd0);
         end else begin
            head_word = expected_words.pop_front();
            if (rsp_tx_level !== head_word.tx_level)
               report_mismatch("tx_level", 32'(rsp_tx_level), 32'(head_word.tx_level));
            if (rsp_tx_taken !== head_word.tx_taken)
               report_mismatch("tx_taken", 32'(rsp_tx_taken), 32'(head_word.tx_taken));
            if (rsp_rx_valid !== head_word.rx_valid)
               report_mismatch("rx_valid", 32'(rsp_rx_valid), 32'(head_word.rx_valid));
            if (rsp_rx_data !== head_word.rx_data)
               report_mismatch("rx_data", 32'(rsp_rx_data), 32'(head_word.rx_data));
            if (rsp_bytes_received !== head_word.bytes_received)
               report_mismatch("bytes_received", rsp_bytes_received, head_word.bytes_received);
            if (head_word.rx_valid)
               bytes_seen++;
         end
         words_checked++;
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------

   // Offer one tick word; valid stays up after acceptance so the next can follow.
   task automatic send_tick(input logic rx, input logic pend, input logic [7:0] data);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_level   <= rx;
      req_tx_pending <= pend;
      req_tx_data    <= data;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_tick(rx, pend, data);
      ticks_sent++;
   endtask

   // Stop offering ticks and wait for every outstanding word.
   task automatic wait_for_drain;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // csr_valid is left high so back-to-back writes need no re-raise.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      if (idx == CSR_TICK_RATE)
         cfg_tick = value[TICK_WIDTH-1:0];
      else if (idx == CSR_BAUD_RATE)
         cfg_baud = value[BAUD_WIDTH-1:0];
   endtask

   task automatic set_rates(input int unsigned tick, input int unsigned baud);
      wait_for_drain();
      write_register(CSR_TICK_RATE, CSR_WIDTH'(tick));
      write_register(CSR_BAUD_RATE, CSR_WIDTH'(baud));
      csr_valid <= 1'b0;
   endtask

   // n ticks at one pin level; flip_odds > 0 inverts a tick with odds 1 in flip_odds.
   task automatic send_level_run(input logic level, input int n, input int flip_odds);
      logic pin;
      for (int i = 0; i < n; i++) begin
         pin = level;
         if (flip_odds > 0 && $urandom_range(1, flip_odds) == 1)
            pin = ~pin;
         send_tick(pin, $urandom_range(0, 3) != 0, 8'($urandom));
      end
   endtask

   // One serial frame at bit_len ticks per bit, preceded by an idle stretch.
   task automatic send_frame(input int bit_len, input logic [7:0] value, input int flip_odds);
      send_level_run(1'b1, $urandom_range(bit_len, 2 * bit_len), flip_odds);
      send_level_run(1'b0, bit_len, flip_odds);
      for (int i = 0; i < 8; i++)
         send_level_run(value[i], bit_len, flip_odds);
      send_level_run(1'b1, bit_len, flip_odds);
      frames_sent++;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset rates, transmit offered while idle and while busy.
   task automatic test_reset_rates;
      send_tick(1'b1, 1'b1, 8'h00);
      send_tick(1'b1, 1'b1, 8'hFF);
      send_tick(1'b0, 1'b0, 8'hA5);
   endtask

   // A short low glitch that is high again at the confirm point.
   task automatic test_glitch_start;
      set_rates(8, 1);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
      send_tick(1'b0, 1'b0, 8'h00);
      repeat (4) send_tick(1'b1, 1'b0, 8'h00);
   endtask

   // Minimum rates, zero baud, baud above range (masked), slowest rate,
   // and a write to an index with no register behind it.
   task automatic test_rate_extremes;
      set_rates(1, 1);
      send_tick(1'b0, 1'b1, 8'hFF);
      send_tick(1'b1, 1'b0, 8'h00);
      send_tick(1'b0, 1'b1, 8'h5A);
      set_rates(1, 0);
      send_tick(1'b0, 1'b1, 8'hC3);
      send_tick(1'b1, 1'b1, 8'h3C);
      // zero thresholds: each phase completes on its first tick
      set_rates(1, 32'(CSR_ALL_ONES));
      send_tick(1'b0, 1'b1, 8'h81);
      send_tick(1'b1, 1'b0, 8'h7E);
      set_rates(32'(TICK_MAX), 1);
      send_tick(1'b0, 1'b1, 8'h01);
      send_tick(1'b1, 1'b1, 8'h80);
      wait_for_drain();
      write_register(CSR_UNUSED, CSR_ALL_ONES);
      csr_valid <= 1'b0;
      send_tick(1'b1, 1'b1, 8'h55);
   endtask

   // Mostly well-formed frames with random bytes, some glitches and noise runs,
   // over several rate settings.
   task automatic test_random_traffic;
      int bit_len;
      int baud;
      int goal;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0) begin
            // fastest legal receive ratio, with baud near the top of its range
            bit_len = 3;
            set_rates(100000000, 33333333);
         end else begin
            bit_len = $urandom_range(3, 6);
            baud    = $urandom_range(1, 5000);
            set_rates(bit_len * baud + $urandom_range(0, baud / 4), baud);
         end
         goal = ticks_sent + 80;
         while (ticks_sent < goal) begin
            if ($urandom_range(0, 4) == 0)
               send_level_run(1'b0, bit_len * $urandom_range(1, 4), 2);
            else
               send_frame(bit_len, 8'($urandom), ($urandom_range(0, 2) == 0) ? 25 : 0);
            // sender pause until the block has answered every tick
            if (phase == 2 && $urandom_range(0, 3) == 0)
               wait_for_drain();
         end
      end
   endtask

   // Back-to-back ticks, no request gaps or response stalls.
   task automatic test_calm_finish;
      int goal;
      set_rates(4 * 115200, 115200);
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      goal = ticks_sent + 80;
      while (ticks_sent < goal)
         send_frame(4, 8'($urandom), 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_rates();
      test_glitch_start();
      test_rate_extremes();
      test_random_traffic();
      test_calm_finish();

      wait_for_drain();
      repeat (200) @(posedge clock);

      $display("%0d ticks driven, %0d words checked, %0d frames sent, %0d bytes received",
               ticks_sent, words_checked, frames_sent, bytes_seen);
      $display("covered reset rates, min/max/zero/masked rates, glitch starts, random rates");
      if (error_count == 0)
         $display("tick_driven_uart_8n1_top: match");
      else
         $display("tick_driven_uart_8n1_top: mismatch");
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin
      #2000000;
      $display("tick_driven_uart_8n1_top: mismatch");
      $finish;
   end

endmodule

// File: files.f
src/tdu_pkg.sv
src/tdu_div.sv
src/tdu_rx.sv
src/tdu_tx.sv
src/tick_driven_uart_8n1_top.sv
test/tb_tick_driven_uart_8n1_top.sv
